[rtl/assert_macros.svh]
// assertion macros for the checker in hwu_checker.sv
// no dependencies; clocked on clk_i, disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HWU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define HWU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/hwu_pkg.sv]
// types and constants for the header whitespace unfolder
// no dependencies
`default_nettype none

package hwu_pkg;

  localparam int unsigned LengthBitsDef = 16;
  localparam int unsigned OutLenW       = 16;

  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;

  typedef struct packed {
    logic [OutLenW-1:0] length;
    logic               last;
    logic               valid;
    logic [7:0]         data;
  } hwu_res_t;

  typedef struct packed {
    hwu_res_t   res0;
    hwu_res_t   res1;
    logic [1:0] npush;
  } hwu_step_t;

endpackage

`default_nettype wire

[rtl/hwu_step.sv]
// per-byte unfolding logic with held line feed, blank run and length state
// depends on hwu_pkg
`default_nettype none

module hwu_step #(
  parameter int unsigned LengthBits = hwu_pkg::LengthBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output hwu_pkg::hwu_step_t step_o
);
  import hwu_pkg::*;

  localparam logic [LengthBits-1:0] CountMax = '1;

  logic                  held_q, held_d;
  logic                  blank_q, blank_d;
  logic [LengthBits-1:0] cnt_q, cnt_d;

  logic                  is_blank;
  logic                  v0, v1;
  logic                  ab1;
  logic [LengthBits-1:0] cnt1, cnt2;
  logic [OutLenW-1:0]    len;
  hwu_res_t              lf_res, cur_res;

  always_comb begin
    is_blank = (byte_i == ChSp) || (byte_i == ChTab);
    v0       = held_q && !is_blank;
    ab1      = v0 ? 1'b0 : blank_q;

    v1      = 1'b0;
    blank_d = ab1;
    if (byte_i == ChCr || byte_i == ChLf) begin
      v1 = 1'b0;
    end else if (is_blank) begin
      v1      = !ab1;
      blank_d = 1'b1;
    end else begin
      v1      = 1'b1;
      blank_d = 1'b0;
    end

    cnt1 = (v0 && cnt_q != CountMax) ? cnt_q + LengthBits'(1) : cnt_q;
    cnt2 = (v1 && cnt1 != CountMax) ? cnt1 + LengthBits'(1) : cnt1;
    len  = OutLenW'(cnt2);

    lf_res.data   = ChLf;
    lf_res.valid  = 1'b1;
    lf_res.last   = last_i && !v1;
    lf_res.length = (last_i && !v1) ? len : '0;

    cur_res.data   = v1 ? byte_i : 8'h00;
    cur_res.valid  = v1;
    cur_res.last   = last_i;
    cur_res.length = last_i ? len : '0;

    step_o.res0 = v0 ? lf_res : cur_res;
    step_o.res1 = cur_res;
    if (v0 && v1) begin
      step_o.npush = 2'd2;
    end else if (v0 || v1 || last_i) begin
      step_o.npush = 2'd1;
    end else begin
      step_o.npush = 2'd0;
    end

    held_d = (byte_i == ChLf) && !last_i;
    cnt_d  = cnt2;
    if (last_i) begin
      blank_d = 1'b0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      blank_q <= 1'b0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      held_q  <= held_d;
      blank_q <= blank_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/header_whitespace_unfolder.sv]
// SIP header unfolding: drops returns, removes folds, squeezes blank runs
// depends on hwu_pkg and hwu_step
//
// A raw message enters one byte per word on the s_axis side, with tlast on
// its final byte. The m_axis side gives the normalized words: the byte and,
// on the word with tlast, the message length, with tuser marking a word that
// carries a byte. A final byte that leaves nothing to emit still gives one
// word with tuser low and tlast high.
// A line feed is held until the next byte arrives; it is dropped if that byte
// is a blank, else its word comes out in the same step as the next byte's.
// The words of an accepted byte are registered in the output queue behind any
// waiting words. Throughput: one byte per cycle while s_axis_tready is high; a
// byte that releases a held line feed and is itself emitted yields two words,
// and the three-word output queue then lowers s_axis_tready until it holds
// at most one word again, the condition under which s_axis_tready is high.
// When the receiver stalls, the queue fills and input stops after at most
// three waiting words; nothing is dropped.
// Reset empties the queue and clears the held line feed, blank run and
// length count; each message also starts from that state after its tlast.
`default_nettype none

module header_whitespace_unfolder #(
  parameter int unsigned LengthBits = hwu_pkg::LengthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // in_byte
  input  logic        s_axis_tlast_i,   // in_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // out_byte [7:0], out_length [23:8]
  output logic        m_axis_tuser_o,   // byte_valid
  output logic        m_axis_tlast_o    // end_of_message
);
  import hwu_pkg::*;

  localparam int unsigned QDepth = 3;

  hwu_step_t  step;
  logic       accept;
  logic       pop;
  logic [1:0] base;

  hwu_res_t   q_q [QDepth];
  hwu_res_t   q_d [QDepth];
  logic [1:0] cnt_q, cnt_d;

  assign s_axis_tready_o = (cnt_q <= 2'd1);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  hwu_step #(
    .LengthBits(LengthBits)
  ) u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .step_o  (step)
  );

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      q_d[i] = q_q[i];
    end
    if (pop) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        q_d[i] = q_q[i+1];
      end
    end
    base  = cnt_q - {1'b0, pop};
    cnt_d = base;
    if (accept) begin
      if (step.npush != 2'd0) begin
        q_d[base] = step.res0;
      end
      if (step.npush == 2'd2) begin
        q_d[base + 2'd1] = step.res1;
      end
      cnt_d = base + step.npush;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign m_axis_tdata_o = {q_q[0].length, q_q[0].data};
  assign m_axis_tuser_o = q_q[0].valid;
  assign m_axis_tlast_o = q_q[0].last;

endmodule

`default_nettype wire

[rtl/hwu_checker.sv]
// port-level checks for the header whitespace unfolder, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hwu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [7:0]  s_axis_tdata_i,
  input wire logic        s_axis_tlast_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // returns never reach the output
  `HWU_ASSERT_NOW(a_no_cr, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o[7:0] != 8'h0D)
  // an empty word only closes a message
  `HWU_ASSERT_NOW(a_empty_last, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tlast_o)
  // length is only reported at the end of a message
  `HWU_ASSERT_NOW(a_len_zero, m_axis_tvalid_o && !m_axis_tlast_o, m_axis_tdata_o[23:8] == 16'h0)
  // stalled word holds
  `HWU_ASSERT_NEXT(a_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

endmodule

bind header_whitespace_unfolder hwu_checker u_hwu_checker (.*);

`default_nettype wire
